@@ sv/marker_pulse_speed_estimator_top_assert.svh @@
// Assertion macros for the marker pulse speed estimator.
// Expects aclk and aresetn in the scope of the including module.
`ifndef MARKER_PULSE_SPEED_ESTIMATOR_TOP_ASSERT_SVH
`define MARKER_PULSE_SPEED_ESTIMATOR_TOP_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define MPSE_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Consequence that must hold on the edge after the antecedent.
`define MPSE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Consequence that must hold on the same edge as the antecedent.
`define MPSE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ sv/mpse_pkg.sv @@
// Types and constants for the marker pulse speed estimator.
// No dependencies; used by mpse_div and the top level.
package mpse_pkg;

    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 16;
    localparam int SPEED_W    = 32;
    localparam int DEV_W      = 9;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Shared divider: 42-bit dividend covers (count-1)*spacing*1000.
    localparam int DIVIDEND_W    = 42;
    localparam int DIVISOR_W     = 32;
    localparam int DIV_SHORT_W   = 32;
    localparam int DIV_STEP      = 2;
    localparam int DIV_LONG_CYC  = DIVIDEND_W / DIV_STEP;
    localparam int DIV_SHORT_CYC = DIV_SHORT_W / DIV_STEP;
    localparam int DIV_CNT_W     = $clog2(DIV_LONG_CYC + 1);

    localparam int MUL_A_W = 32;
    localparam int MUL_B_W = 16;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_MEAS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_DEV  = 2'd2;

    localparam logic [COUNT_W-1:0]    MIN_MEAS_RESET = 16'd3;
    localparam logic [CFG_DATA_W-1:0] SPACING_RESET  = 16'd100;
    localparam logic [DEV_W-1:0]      MAX_DEV_RESET  = 9'd64;
    localparam logic [COUNT_W-1:0]    MIN_MEAS_FLOOR = 16'd2;
    localparam logic [DEV_W-1:0]      MAX_DEV_CEIL   = 9'd256;
    localparam logic [MUL_B_W-1:0]    SPEED_SCALE    = 16'd1000;
    localparam logic [COUNT_W-1:0]    COUNT_MAX      = 16'hFFFF;
    localparam logic [SPEED_W-1:0]    SPEED_MAX      = 32'hFFFF_FFFF;

    localparam logic KIND_EDGE    = 1'b0;
    localparam logic KIND_RESTART = 1'b1;

    typedef struct packed {
        logic              kind;
        logic [TIME_W-1:0] event_time_ms;
    } mpse_in_t;

    typedef struct packed {
        logic               edge_accepted;
        logic [COUNT_W-1:0] edge_count;
        logic               speed_valid;
        logic [SPEED_W-1:0] speed_mm_per_s;
    } mpse_out_t;

    typedef struct packed {
        logic                  start;
        logic                  short_op;
        logic [DIVIDEND_W-1:0] dividend;
        logic [DIVISOR_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIVIDEND_W-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EVAL,
        ST_AVG_DIV,
        ST_DEV_MUL,
        ST_BOUND,
        ST_SPD_CHK,
        ST_MUL1,
        ST_MUL2,
        ST_SPD_DIV,
        ST_OUT
    } state_t;

endpackage

@@ sv/mpse_div.sv @@
// Shared restoring divider, two quotient bits per cycle.
// Depends on mpse_pkg for widths and the request/response structs.
module mpse_div import mpse_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [DIV_CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;

    logic [DIVISOR_W-1:0]  rem_step;
    logic [DIVIDEND_W-1:0] quo_step;
    logic [DIVISOR_W:0]    trial;

    always_comb begin
        rem_step = rem_reg;
        quo_step = quo_reg;
        trial    = '0;
        for (int i = 0; i < DIV_STEP; i++) begin
            trial = {rem_step, quo_step[DIVIDEND_W-1]};
            if (trial >= {1'b0, dsr_reg}) begin
                trial    = trial - {1'b0, dsr_reg};
                quo_step = {quo_step[DIVIDEND_W-2:0], 1'b1};
            end else begin
                quo_step = {quo_step[DIVIDEND_W-2:0], 1'b0};
            end
            rem_step = trial[DIVISOR_W-1:0];
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (req.start) begin
            busy_next = 1'b1;
            rem_next  = '0;
            dsr_next  = req.divisor;
            // short operands sit in the top bits so fewer steps suffice
            if (req.short_op) begin
                cnt_next = DIV_CNT_W'(DIV_SHORT_CYC);
                quo_next = {req.dividend[DIV_SHORT_W-1:0],
                            {(DIVIDEND_W-DIV_SHORT_W){1'b0}}};
            end else begin
                cnt_next = DIV_CNT_W'(DIV_LONG_CYC);
                quo_next = req.dividend;
            end
        end else if (busy_reg) begin
            rem_next = rem_step;
            quo_next = quo_step;
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

@@ sv/marker_pulse_speed_estimator_top.sv @@
// Marker pulse speed estimator: one beat in flight, s_ready high only in idle. From ST_EVAL a
// restart goes to ST_OUT, an edge below the minimum via ST_SPD_CHK, and the edge that reaches
// it also via ST_MUL1, ST_MUL2 and the speed divide; a filtered edge runs the average divide,
// ST_DEV_MUL and ST_BOUND, then is dropped to ST_OUT or kept on that speed path. ST_OUT waits
// until the output register is free; s_ready returns as the result is registered. Sync
// active-low reset clears state and loads register defaults (minimum 3, spacing 100 mm, deviation 64/256).
module marker_pulse_speed_estimator_top import mpse_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  mpse_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output mpse_out_t             m_data
);

`include "marker_pulse_speed_estimator_top_assert.svh"

    state_t state_reg, state_next;

    logic [COUNT_W-1:0]    min_reg;
    logic [CFG_DATA_W-1:0] spacing_reg;
    logic [DEV_W-1:0]      devq_reg;

    logic                  kind_reg, kind_next;
    logic [TIME_W-1:0]     time_reg, time_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [TIME_W-1:0]     start_reg, start_next;
    logic [TIME_W-1:0]     last_reg, last_next;
    logic [SPEED_W-1:0]    speed_reg, speed_next;
    logic [TIME_W-1:0]     avg_reg, avg_next;
    logic [TIME_W-1:0]     dev_reg, dev_next;
    logic [MUL_A_W-1:0]    work_reg, work_next;
    logic                  acc_reg, acc_next;
    logic                  m_valid_reg, m_valid_next;
    mpse_out_t             m_data_reg, m_data_next;

    logic [COUNT_W-1:0]    eff_min;
    logic [DEV_W-1:0]      eff_dev;
    logic [TIME_W-1:0]     elapsed;
    logic [TIME_W-1:0]     delta;
    logic [TIME_W-1:0]     bound_lo;
    logic [TIME_W:0]       bound_hi;
    logic                  in_range;
    logic                  below_min;
    logic                  out_load;
    logic [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic [MUL_P_W-1:0]    prod;
    logic [COUNT_W-1:0]    count_inc;
    logic                  now_valid;

    div_req_t div_req;
    div_rsp_t div_rsp;

    mpse_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg     <= MIN_MEAS_RESET;
            spacing_reg <= SPACING_RESET;
            devq_reg    <= MAX_DEV_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_MIN_MEAS: min_reg     <= cfg_wdata;
                CFG_SPACING:  spacing_reg <= cfg_wdata;
                CFG_MAX_DEV:  devq_reg    <= cfg_wdata[DEV_W-1:0];
                default: ;
            endcase
        end
    end

    assign eff_min   = (min_reg < MIN_MEAS_FLOOR) ? MIN_MEAS_FLOOR : min_reg;
    assign eff_dev   = (devq_reg > MAX_DEV_CEIL) ? MAX_DEV_CEIL : devq_reg;
    assign elapsed   = last_reg - start_reg;
    assign delta     = time_reg - last_reg;
    assign bound_lo  = avg_reg - dev_reg;
    assign bound_hi  = {1'b0, avg_reg} + {1'b0, dev_reg};
    assign in_range  = (delta > bound_lo) && ({1'b0, delta} < bound_hi);
    assign below_min = count_reg < eff_min;
    assign out_load  = (state_reg == ST_OUT) && (!m_valid_reg || m_ready);
    assign count_inc = (count_reg == COUNT_MAX) ? count_reg : count_reg + COUNT_W'(1);
    assign now_valid = !below_min;

    // shared multiplier
    always_comb begin
        unique case (state_reg)
            ST_DEV_MUL: begin
                mul_a = avg_reg;
                mul_b = MUL_B_W'(eff_dev);
            end
            ST_MUL1: begin
                mul_a = MUL_A_W'(count_reg - COUNT_W'(1));
                mul_b = spacing_reg;
            end
            ST_MUL2: begin
                mul_a = work_reg;
                mul_b = SPEED_SCALE;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:    if (s_valid) state_next = ST_EVAL;
            ST_EVAL: begin
                if (kind_reg == KIND_RESTART) begin
                    state_next = ST_OUT;
                end else if (below_min) begin
                    state_next = ST_SPD_CHK;
                end else begin
                    state_next = ST_AVG_DIV;
                end
            end
            ST_AVG_DIV: if (div_rsp.done) state_next = ST_DEV_MUL;
            ST_DEV_MUL: state_next = ST_BOUND;
            ST_BOUND:   state_next = in_range ? ST_SPD_CHK : ST_OUT;
            ST_SPD_CHK: begin
                if (below_min || elapsed == '0) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_MUL1;
                end
            end
            ST_MUL1:    state_next = ST_MUL2;
            ST_MUL2:    state_next = ST_SPD_DIV;
            ST_SPD_DIV: if (div_rsp.done) state_next = ST_OUT;
            ST_OUT:     if (out_load) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        kind_next    = kind_reg;
        time_next    = time_reg;
        count_next   = count_reg;
        start_next   = start_reg;
        last_next    = last_reg;
        speed_next   = speed_reg;
        avg_next     = avg_reg;
        dev_next     = dev_reg;
        work_next    = work_reg;
        acc_next     = acc_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg;
        div_req      = '0;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next = s_data.kind;
                    time_next = s_data.event_time_ms;
                end
            end
            ST_EVAL: begin
                acc_next = 1'b0;
                if (kind_reg == KIND_RESTART) begin
                    count_next = '0;
                    start_next = time_reg;
                    last_next  = time_reg;
                    speed_next = '0;
                end else if (below_min) begin
                    // every edge counts until the minimum is reached
                    if (count_reg == '0) start_next = time_reg;
                    acc_next   = 1'b1;
                    count_next = count_inc;
                    last_next  = time_reg;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.short_op = 1'b1;
                    div_req.dividend = DIVIDEND_W'(elapsed);
                    div_req.divisor  = DIVISOR_W'(count_reg - COUNT_W'(1));
                end
            end
            ST_AVG_DIV: begin
                if (div_rsp.done) avg_next = div_rsp.quotient[TIME_W-1:0];
            end
            ST_DEV_MUL: begin
                dev_next = prod[TIME_W+7:8];
            end
            ST_BOUND: begin
                if (in_range) begin
                    acc_next   = 1'b1;
                    count_next = count_inc;
                    last_next  = time_reg;
                end
            end
            ST_SPD_CHK: begin
                if (below_min) begin
                    speed_next = '0;
                end else if (elapsed == '0) begin
                    speed_next = SPEED_MAX;
                end
            end
            ST_MUL1: begin
                work_next = prod[MUL_A_W-1:0];
            end
            ST_MUL2: begin
                div_req.start    = 1'b1;
                div_req.short_op = 1'b0;
                div_req.dividend = prod[DIVIDEND_W-1:0];
                div_req.divisor  = elapsed;
            end
            ST_SPD_DIV: begin
                if (div_rsp.done) begin
                    // saturate when the quotient spills past 32 bits
                    if (div_rsp.quotient[DIVIDEND_W-1:SPEED_W] != '0) begin
                        speed_next = SPEED_MAX;
                    end else begin
                        speed_next = div_rsp.quotient[SPEED_W-1:0];
                    end
                end
            end
            ST_OUT: begin
                if (out_load) begin
                    m_valid_next               = 1'b1;
                    m_data_next.edge_accepted  = acc_reg;
                    m_data_next.edge_count     = count_reg;
                    m_data_next.speed_valid    = now_valid;
                    m_data_next.speed_mm_per_s = now_valid ? speed_reg : '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            start_reg   <= '0;
            last_reg    <= '0;
            speed_reg   <= '0;
            acc_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            start_reg   <= start_next;
            last_reg    <= last_next;
            speed_reg   <= speed_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        time_reg   <= time_next;
        avg_reg    <= avg_next;
        dev_reg    <= dev_next;
        work_reg   <= work_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `MPSE_ASSERT_SAME(a_div_start_idle, div_req.start, !div_rsp.busy, "divider restarted while busy")
    `MPSE_ASSERT_SAME(a_div_nonzero, div_req.start, div_req.divisor != '0, "divide by zero issued")
    `MPSE_ASSERT_NEXT(a_one_in_flight, s_valid && s_ready, !s_ready, "second beat taken while busy")
    `MPSE_ASSERT_NEXT(a_restart_clears, out_load && kind_reg == KIND_RESTART, m_data_reg.edge_count == '0 && !m_data_reg.edge_accepted, "restart result not cleared")
    `MPSE_ASSERT_ALWAYS(a_valid_count, !(m_valid && m_data.speed_valid) || m_data.edge_count >= MIN_MEAS_FLOOR, "speed valid below two edges")

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for marker_pulse_speed_estimator_top.
// Predicts every result beat from its own model of the edge filter and speed maths.
// Depends on mpse_pkg and the top level only.
module tb import mpse_pkg::*; ();

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 400;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    mpse_in_t              s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    mpse_out_t             m_data;

    marker_pulse_speed_estimator_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    mpse_in_t  marker_q[$];
    mpse_out_t speed_exp_q[$];

    int n_sent   = 0;
    int n_got    = 0;
    int n_fail   = 0;
    int cycles   = 0;
    int tx_idle;
    int rx_idle;
    logic s_took = 1'b0;

    // Predictor state and register copies
    logic [COUNT_W-1:0]    mdl_min;
    logic [CFG_DATA_W-1:0] mdl_spacing;
    logic [DEV_W-1:0]      mdl_dev;
    logic [COUNT_W-1:0]    mdl_count;
    logic [TIME_W-1:0]     mdl_start;
    logic [TIME_W-1:0]     mdl_last;
    logic [SPEED_W-1:0]    mdl_speed;

    assign tx_idle = (n_sent < 300) ? 27 : (n_sent < 600) ? 73 : 0;
    assign rx_idle = (n_sent < 300) ? 73 : (n_sent < 600) ? 27 : 0;

    function automatic mpse_out_t speed_predict(mpse_in_t beat);
        mpse_out_t         res;
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] total;
        logic [TIME_W-1:0] delta;
        logic [TIME_W-1:0] avg;
        logic [TIME_W-1:0] elapsed;
        logic [63:0]       dev;
        logic [63:0]       num;
        logic [63:0]       quo;
        int unsigned       min_eff;
        int unsigned       dev_eff;
        logic              taken;
        t       = beat.event_time_ms;
        taken   = 1'b0;
        min_eff = 32'((mdl_min < MIN_MEAS_FLOOR) ? MIN_MEAS_FLOOR : mdl_min);
        dev_eff = 32'((mdl_dev > MAX_DEV_CEIL) ? MAX_DEV_CEIL : mdl_dev);
        if (beat.kind == KIND_RESTART) begin
            mdl_count = '0;
            mdl_start = t;
            mdl_last  = t;
            mdl_speed = '0;
        end else begin
            if (mdl_count == 0)
                mdl_start = t;
            taken = 1'b1;
            // Filter only once the minimum is reached; the upper bound must not wrap
            if (mdl_count >= min_eff) begin
                total = mdl_last - mdl_start;
                delta = t - mdl_last;
                avg   = total / (32'(mdl_count) - 32'd1);
                dev   = (64'(avg) * 64'(dev_eff)) >> 8;
                taken = (64'(delta) > 64'(avg) - dev) && (64'(delta) < 64'(avg) + dev);
            end
            if (taken) begin
                if (mdl_count != COUNT_MAX)
                    mdl_count = mdl_count + 1'b1;
                mdl_last = t;
                // Elapsed time wraps at 32 bits
                elapsed  = mdl_last - mdl_start;
                if (mdl_count < min_eff) begin
                    mdl_speed = '0;
                end else if (elapsed == '0) begin
                    mdl_speed = SPEED_MAX;
                end else begin
                    num = (64'(mdl_count) - 64'd1) * 64'(mdl_spacing) * 64'd1000;
                    quo = num / 64'(elapsed);
                    mdl_speed = (quo > 64'(SPEED_MAX)) ? SPEED_MAX : quo[SPEED_W-1:0];
                end
            end
        end
        res.edge_accepted  = taken;
        res.edge_count     = mdl_count;
        res.speed_valid    = (mdl_count >= min_eff);
        res.speed_mm_per_s = res.speed_valid ? mdl_speed : '0;
        return res;
    endfunction

    // Input side: register copies, predictions and the accept flag for the driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            mdl_min     <= MIN_MEAS_RESET;
            mdl_spacing <= SPACING_RESET;
            mdl_dev     <= MAX_DEV_RESET;
            mdl_count   = '0;
            mdl_start   = '0;
            mdl_last    = '0;
            mdl_speed   = '0;
            s_took      <= 1'b0;
        end else begin
            s_took <= s_valid && s_ready;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_MIN_MEAS: mdl_min     <= cfg_wdata;
                    CFG_SPACING:  mdl_spacing <= cfg_wdata;
                    CFG_MAX_DEV:  mdl_dev     <= cfg_wdata[DEV_W-1:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                speed_exp_q.push_back(speed_predict(s_data));
                n_sent <= n_sent + 1;
            end
        end
    end

    // Sender: hold the beat until taken, then offer the next or idle
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_took) begin
            if (marker_q.size() != 0 && $urandom_range(0, 99) >= tx_idle) begin
                s_valid <= 1'b1;
                s_data  <= marker_q.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off to back up the input
    int  hold_left = 0;
    bit  held      = 1'b0;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else if (!held && n_got >= 150 && marker_q.size() > 10) begin
            held      <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_idle);
        end
    end

    // Result side
    always @(posedge aclk) begin
        mpse_out_t want;
        if (aresetn) begin
            cycles <= cycles + 1;
            if (cycles >= CYCLE_LIMIT) begin
                $display("%0t: timeout after %0d cycles", $time, cycles);
                $display("Test completed with failures");
                $finish;
            end
            if (m_valid && m_ready) begin
                n_got <= n_got + 1;
                if (speed_exp_q.size() == 0) begin
                    $display("%0t: unexpected result beat, expected none, got %h",
                             $time, m_data);
                    n_fail++;
                end else begin
                    want = speed_exp_q.pop_front();
                    if (m_data.edge_accepted !== want.edge_accepted) begin
                        $display("%0t: edge_accepted expected %0d, got %0d",
                                 $time, want.edge_accepted, m_data.edge_accepted);
                        n_fail++;
                    end
                    if (m_data.edge_count !== want.edge_count) begin
                        $display("%0t: edge_count expected %0d, got %0d",
                                 $time, want.edge_count, m_data.edge_count);
                        n_fail++;
                    end
                    if (m_data.speed_valid !== want.speed_valid) begin
                        $display("%0t: speed_valid expected %0d, got %0d",
                                 $time, want.speed_valid, m_data.speed_valid);
                        n_fail++;
                    end
                    if (m_data.speed_mm_per_s !== want.speed_mm_per_s) begin
                        $display("%0t: speed_mm_per_s expected %0d, got %0d",
                                 $time, want.speed_mm_per_s, m_data.speed_mm_per_s);
                        n_fail++;
                    end
                end
            end
        end
    end

    int n_pushed = 0;

    task automatic push_marker(input logic kind, input logic [TIME_W-1:0] t);
        marker_q.push_back(mpse_in_t'{kind: kind, event_time_ms: t});
        n_pushed++;
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Wait until every beat is sent and answered, then let the block go quiet
    task automatic settle();
        while (marker_q.size() != 0 || s_valid || speed_exp_q.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin
        logic [TIME_W-1:0]     t;
        logic [TIME_W-1:0]     t0;
        logic [COUNT_W-1:0]    g_min;
        logic [CFG_DATA_W-1:0] g_spc;
        logic [DEV_W-1:0]      g_dev;
        longint unsigned       jit;
        int unsigned           period;
        int unsigned           dev_eff;
        int                    phase;
        int                    phase_start;
        int                    train_len;
        int                    roll;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: register defaults, filter bounds, zero elapsed time, timestamp wrap
        push_marker(KIND_EDGE, 32'd1000);
        push_marker(KIND_EDGE, 32'd1100);
        push_marker(KIND_EDGE, 32'd1200);
        push_marker(KIND_EDGE, 32'd1300);
        push_marker(KIND_EDGE, 32'd1376);
        push_marker(KIND_EDGE, 32'd1447);   // interval on the lower bound: drop
        push_marker(KIND_EDGE, 32'd1493);   // interval on the upper bound: drop
        push_marker(KIND_EDGE, 32'd1448);
        push_marker(KIND_RESTART, 32'hFFFF_FF00);
        repeat (4) push_marker(KIND_EDGE, 32'hFFFF_FF00);
        push_marker(KIND_RESTART, 32'hFFFF_FFF0);
        push_marker(KIND_EDGE, 32'hFFFF_FFF0);
        push_marker(KIND_EDGE, 32'h0000_0010);
        push_marker(KIND_EDGE, 32'h0000_0030);
        push_marker(KIND_EDGE, 32'h0000_0050);
        push_marker(KIND_RESTART, 32'hFFFF_FFFF);
        push_marker(KIND_EDGE, 32'h0000_0000);
        push_marker(KIND_EDGE, 32'hFFFF_FFFF);
        push_marker(KIND_EDGE, 32'h8000_0000);
        settle();

        // Speed overflow: many edges on one timestamp, then two more a millisecond apart
        cfg_write(CFG_MIN_MEAS, 16'd70);
        cfg_write(CFG_SPACING, 16'hFFFF);
        cfg_write(CFG_MAX_DEV, 16'd64);
        t0 = $urandom;
        push_marker(KIND_RESTART, t0);
        repeat (69) push_marker(KIND_EDGE, t0);
        push_marker(KIND_EDGE, t0 + 32'd1);
        push_marker(KIND_EDGE, t0 + 32'd2);
        settle();

        // Random phases: register settings, then mostly clean marker trains
        phase = 0;
        while (n_pushed < 800) begin
            if (phase == 0) begin
                g_min = 16'd0;  g_spc = 16'd1;     g_dev = 9'd0;
            end else if (phase == 1) begin
                g_min = 16'd1;  g_spc = 16'hFFFF;  g_dev = 9'd256;
            end else if (phase == 2) begin
                g_min = 16'd2;  g_spc = 16'($urandom_range(1, 65535));  g_dev = 9'd511;
            end else if (phase == 3) begin
                g_min = 16'hFFFF;  g_spc = 16'($urandom_range(1, 65535));  g_dev = 9'd257;
            end else begin
                g_min = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 65535))
                                                    : 16'($urandom_range(0, 8));
                g_spc = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(1, 65535))
                                                    : 16'($urandom_range(1, 1000));
                g_dev = ($urandom_range(0, 7) == 0) ? 9'($urandom_range(0, 511))
                                                    : 9'($urandom_range(16, 200));
            end
            cfg_write(CFG_MIN_MEAS, g_min);
            cfg_write(CFG_SPACING, g_spc);
            cfg_write(CFG_MAX_DEV, {7'($urandom), g_dev});
            dev_eff = (g_dev > 9'd256) ? 256 : g_dev;

            phase_start = n_pushed;
            while (n_pushed - phase_start < 70) begin
                roll = $urandom_range(0, 99);
                if (roll < 70)
                    period = $urandom_range(1, 3000);
                else if (roll < 95)
                    period = $urandom_range(1, 32'h0100_0000);
                else
                    period = $urandom_range(0, 3);
                train_len = $urandom_range(3, 24);
                t = $urandom;
                if ($urandom_range(0, 9) != 0)
                    push_marker(KIND_RESTART, t);
                for (int i = 0; i < train_len; i++) begin
                    roll = $urandom_range(0, 99);
                    if (roll < 8) begin
                        push_marker(KIND_EDGE, $urandom);
                    end else if (roll < 11) begin
                        push_marker(1'($urandom), $urandom);
                    end else begin
                        // Keep the jitter well inside the allowed band
                        jit = (longint'(period) * dev_eff) / 512;
                        t = t + 32'(period + $urandom_range(0, 2 * jit) - jit);
                        push_marker(KIND_EDGE, t);
                    end
                end
            end
            settle();
            phase++;
        end

        settle();
        if (n_fail == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
